>>> hw/rtl/vse_pkg.sv
`default_nettype none

package vse_pkg;

   // default volume limits
   localparam int DEF_MAX_X = 128;
   localparam int DEF_MAX_Y = 128;
   localparam int DEF_MAX_Z = 128;

   // field widths
   localparam int DATA_W = 32;
   localparam int POS_W  = 7;
   localparam int SIZE_W = 8;

   // stream packing
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_PAD_W   = RSP_TDATA_W - DATA_W - 3 * POS_W;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X = 2'd0,
      CSR_SIZE_Y = 2'd1,
      CSR_SIZE_Z = 2'd2,
      CSR_CUTOFF = 2'd3
   } csr_index_type;

   localparam logic [SIZE_W-1:0] SIZE_RESET   = 8'd128;
   localparam logic [DATA_W-1:0] CUTOFF_RESET = 32'd0;

   // tuser code on the input side
   localparam logic REQ_KIND_FLUSH = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/vse_ram.sv
`default_nettype none

module vse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write, one registered read; same address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/vse_delay.sv
`default_nettype none

// Programmable delay of len pushes, built as a ring over one RAM.
module vse_delay #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int LEN_W  = $clog2(DEPTH + 1),
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [LEN_W-1:0] len,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);

   logic [ADDR_W-1:0] ptr_ff;
   logic [ADDR_W-1:0] ptr_in;

   // pointer wraps at len-1, also when len shrank below it
   always_comb begin
      ptr_in = ptr_ff;
      if (push) begin
         if ((LEN_W + 1)'(ptr_ff) + (LEN_W + 1)'(1) >= (LEN_W + 1)'(len)) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   // read-before-write at the same slot gives the word pushed len pushes ago
   vse_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (ptr_ff),
      .wr_data (din),
      .rd_en   (push),
      .rd_addr (ptr_ff),
      .rd_data (dout)
   );

endmodule

`default_nettype wire

>>> hw/rtl/volume_surface_extract_3d.sv
// Six-neighbor surface extraction over a voxel volume streamed in raster
// order (x fastest, then y, then z).
// req channel: one voxel per item, tdata = density (signed Q16.16), tuser = 1
// marks a flush item that pushes a zero voxel to drain the last plane.
// rsp channel: one item per centre voxel in raster order, tdata = value,
// pos_x, pos_y, pos_z; tuser = surface flag; tlast on the final voxel.
// csr port: size_x, size_y, size_z, cutoff; write only while idle.
// Throughput: one item per cycle while rsp does not stall. Each item makes one
// read and one write in each of four delay RAMs (two of about a plane, two of
// about a row), and the seven-tap compare sits between the tap registers and
// the result register. The accepting edge loads the tap stage, which passes its
// item on once the result register is empty or its result is being taken.
// The first sx*sy items after reset or after a flush-drained volume
// give no result. Volumes may follow each other without flushes.
// Reset clears the counters and loads the register defaults; the delay RAMs
// are not cleared and need no clearing pass.
// When rsp stalls with the result register and the tap stage both full,
// req_tready drops until the result is taken.
`default_nettype none

module volume_surface_extract_3d
   import vse_pkg::*;
#(
   parameter int MAX_X = DEF_MAX_X,
   parameter int MAX_Y = DEF_MAX_Y,
   parameter int MAX_Z = DEF_MAX_Z
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: voxel_value[31:0]
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: req_type[0]
   input  wire logic                   req_tuser,
   // rsp_tdata: out_value[31:0], pos_x[38:32], pos_y[45:39], pos_z[52:46], zero pad
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // rsp_tuser: is_surface[0]
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int XW  = $clog2(MAX_X + 1);
   localparam int YW  = $clog2(MAX_Y + 1);
   localparam int ZW  = $clog2(MAX_Z + 1);
   localparam int CXW = $clog2(MAX_X);
   localparam int CYW = $clog2(MAX_Y);
   localparam int CZW = $clog2(MAX_Z);
   localparam int PW  = $clog2(MAX_X * MAX_Y + 1);
   localparam int DEPTH_A = MAX_X * MAX_Y - MAX_X - 1;
   localparam int DEPTH_B = MAX_X - 2;
   localparam int LAW = $clog2(DEPTH_A + 1);
   localparam int LBW = $clog2(DEPTH_B + 1);

   // registers
   logic [SIZE_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic signed [DATA_W-1:0] cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
         cutoff_ff <= CUTOFF_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SIZE_X: size_x_ff <= csr_wr_data[SIZE_W-1:0];
            CSR_SIZE_Y: size_y_ff <= csr_wr_data[SIZE_W-1:0];
            CSR_SIZE_Z: size_z_ff <= csr_wr_data[SIZE_W-1:0];
            CSR_CUTOFF: cutoff_ff <= csr_wr_data[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   // effective sizes: zero acts as one, too large acts as the maximum
   logic [XW-1:0]  sx;
   logic [YW-1:0]  sy;
   logic [ZW-1:0]  sz;
   logic [PW-1:0]  plane;
   logic [LAW-1:0] len_a;
   logic [LBW-1:0] len_b;

   assign sx = (size_x_ff == '0) ? XW'(1) :
               (32'(size_x_ff) > 32'(MAX_X)) ? XW'(MAX_X) : XW'(size_x_ff);
   assign sy = (size_y_ff == '0) ? YW'(1) :
               (32'(size_y_ff) > 32'(MAX_Y)) ? YW'(MAX_Y) : YW'(size_y_ff);
   assign sz = (size_z_ff == '0) ? ZW'(1) :
               (32'(size_z_ff) > 32'(MAX_Z)) ? ZW'(MAX_Z) : ZW'(size_z_ff);
   assign plane = PW'(sx) * PW'(sy);

   // segment lengths; small volumes have no interior, so any length will do
   assign len_a = ((PW + 1)'(plane) > (PW + 1)'(sx) + (PW + 1)'(1)) ?
                  LAW'(plane - PW'(sx) - PW'(1)) : LAW'(1);
   assign len_b = (sx > XW'(2)) ? LBW'(sx - XW'(2)) : LBW'(1);

   // control state
   logic [PW-1:0]  fill_ff, fill_in;
   logic           volume_done_ff, volume_done_in;
   logic [CXW-1:0] out_x_ff, out_x_in;
   logic [CYW-1:0] out_y_ff, out_y_in;
   logic [CZW-1:0] out_z_ff, out_z_in;

   // tap stage
   logic           s1_valid_ff, s1_valid_in;
   logic           s1_inner_ff;
   logic           s1_last_ff;
   logic [CXW-1:0] s1_x_ff;
   logic [CYW-1:0] s1_y_ff;
   logic [CZW-1:0] s1_z_ff;

   // result register
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic                     rsp_surf_ff;
   logic                     rsp_last_ff;
   logic [POS_W-1:0]         rsp_px_ff, rsp_py_ff, rsp_pz_ff;

   logic accept, flush, push, filling, produce, s2_load;
   logic x_more, y_more, z_more, inner, is_last;

   assign s2_load    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s2_load;
   assign accept     = req_tvalid && req_tready;
   assign flush      = (req_tuser == REQ_KIND_FLUSH);
   // a flush after a finished volume is dropped without touching anything
   assign push       = accept && !(flush && volume_done_ff);
   assign filling    = fill_ff < plane;
   assign produce    = push && !filling;

   // position of the centre voxel
   assign x_more  = XW'(out_x_ff) + XW'(1) < sx;
   assign y_more  = YW'(out_y_ff) + YW'(1) < sy;
   assign z_more  = ZW'(out_z_ff) + ZW'(1) < sz;
   assign inner   = (out_x_ff != '0) && x_more && (out_y_ff != '0) && y_more &&
                    (out_z_ff != '0) && z_more;
   assign is_last = !x_more && !y_more && !z_more;

   // next control state
   always_comb begin
      fill_in        = fill_ff;
      volume_done_in = volume_done_ff;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_z_in       = out_z_ff;
      if (push) begin
         if (!flush) begin
            volume_done_in = 1'b0;
         end
         if (filling) begin
            fill_in = fill_ff + PW'(1);
         end else begin
            // raster advance; the last voxel wraps all three to zero
            if (x_more) begin
               out_x_in = out_x_ff + CXW'(1);
            end else begin
               out_x_in = '0;
               if (y_more) begin
                  out_y_in = out_y_ff + CYW'(1);
               end else begin
                  out_y_in = '0;
                  out_z_in = z_more ? out_z_ff + CZW'(1) : '0;
               end
            end
            if (is_last) begin
               volume_done_in = 1'b1;
               if (flush) begin
                  fill_in = '0;
               end
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (produce) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         volume_done_ff <= 1'b0;
         out_x_ff       <= '0;
         out_y_ff       <= '0;
         out_z_ff       <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         fill_ff        <= fill_in;
         volume_done_ff <= volume_done_in;
         out_x_ff       <= out_x_in;
         out_y_ff       <= out_y_in;
         out_z_ff       <= out_z_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         s1_inner_ff <= inner;
         s1_last_ff  <= is_last;
         s1_x_ff     <= out_x_ff;
         s1_y_ff     <= out_y_ff;
         s1_z_ff     <= out_z_ff;
      end
   end

   // delay line: r0, ring A, ring B, centre, +1, ring C, ring D
   logic [DATA_W-1:0] push_value;
   logic [DATA_W-1:0] tap_0_ff, tap_c_ff, tap_p1_ff;
   logic [DATA_W-1:0] tap_m_row, tap_m1, tap_p_row, tap_p_plane;

   assign push_value = flush ? '0 : req_tdata[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (push) begin
         tap_0_ff  <= push_value;
         tap_c_ff  <= tap_m1;
         tap_p1_ff <= tap_c_ff;
      end
   end

   vse_delay #(.WIDTH(DATA_W), .DEPTH(DEPTH_A)) u_ring_a (
      .clock (clock), .reset (reset), .push (push), .len (len_a),
      .din (tap_0_ff), .dout (tap_m_row)
   );

   vse_delay #(.WIDTH(DATA_W), .DEPTH(DEPTH_B)) u_ring_b (
      .clock (clock), .reset (reset), .push (push), .len (len_b),
      .din (tap_m_row), .dout (tap_m1)
   );

   vse_delay #(.WIDTH(DATA_W), .DEPTH(DEPTH_B)) u_ring_c (
      .clock (clock), .reset (reset), .push (push), .len (len_b),
      .din (tap_p1_ff), .dout (tap_p_row)
   );

   vse_delay #(.WIDTH(DATA_W), .DEPTH(DEPTH_A)) u_ring_d (
      .clock (clock), .reset (reset), .push (push), .len (len_a),
      .din (tap_p_row), .dout (tap_p_plane)
   );

   // seven-tap threshold compare
   logic le_c, le_n, surf;

   assign le_c = $signed(tap_c_ff) <= cutoff_ff;
   assign le_n = ($signed(tap_m1) <= cutoff_ff) || ($signed(tap_p1_ff) <= cutoff_ff) ||
                 ($signed(tap_m_row) <= cutoff_ff) || ($signed(tap_p_row) <= cutoff_ff) ||
                 ($signed(tap_0_ff) <= cutoff_ff) || ($signed(tap_p_plane) <= cutoff_ff);
   assign surf = s1_inner_ff && !le_c && le_n;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_value_ff <= surf ? tap_c_ff : '0;
         rsp_surf_ff  <= surf;
         rsp_last_ff  <= s1_last_ff;
         rsp_px_ff    <= POS_W'(s1_x_ff);
         rsp_py_ff    <= POS_W'(s1_y_ff);
         rsp_pz_ff    <= POS_W'(s1_z_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_pz_ff, rsp_py_ff, rsp_px_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_surf_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("item accepted while tap stage and result register are full");

   a_done_at_origin: assert property (@(posedge clock) disable iff (reset)
      volume_done_ff |-> (out_x_ff == '0) && (out_y_ff == '0) && (out_z_ff == '0))
      else $error("finished volume left the output position off the origin");

   a_extra_flush_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_KIND_FLUSH) && volume_done_ff
      |=> !s1_valid_ff)
      else $error("dropped flush produced a result");

endmodule

`default_nettype wire

>>> tb/tb_volume_surface_extract_3d.sv
module tb_volume_surface_extract_3d;
   import vse_pkg::*;

   localparam int          LINE_DEPTH  = 2 * DEF_MAX_X * DEF_MAX_Y + 1;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int          HOLD_PHASE  = 4;
   localparam int          NUM_PHASES  = 10;
   localparam int          NUM_ROWS    = 12;
   localparam logic        KIND_DATA   = ~REQ_KIND_FLUSH;

   typedef enum logic [1:0] {CUT_ZERO, CUT_MIN, CUT_MAX, CUT_RANDOM} cutoff_kind_type;
   typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_SPARSE}
      ready_mode_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              surface;
      logic [POS_W-1:0]  px;
      logic [POS_W-1:0]  py;
      logic [POS_W-1:0]  pz;
      logic              last;
   } voxel_result_type;

   // hand-checked rows on a 1x1x2 volume: every voxel sits on the border
   typedef struct packed {
      logic              flush;
      logic [DATA_W-1:0] value;
      logic              has_rsp;
      logic [POS_W-1:0]  z;
      logic              last;
   } directed_row_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size_x;
      logic [SIZE_W-1:0] size_y;
      logic [SIZE_W-1:0] size_z;
      cutoff_kind_type   cut;
      logic [3:0]        volumes;
   } test_phase_type;

   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{1'b1, 32'hDEAD_BEEF, 1'b0, 7'd0, 1'b0},  // flush while filling
      '{1'b0, 32'h7FFF_FFFF, 1'b1, 7'd0, 1'b0},
      '{1'b0, 32'h8000_0000, 1'b1, 7'd1, 1'b1},
      '{1'b1, 32'h0F0F_0F0F, 1'b0, 7'd0, 1'b0},  // extra flush, ignored
      '{1'b0, 32'hFFFF_FFFF, 1'b1, 7'd0, 1'b0},  // next volume back to back
      '{1'b1, 32'hFFFF_FFFF, 1'b1, 7'd1, 1'b1},  // flush drains the volume
      '{1'b1, 32'h0000_0000, 1'b0, 7'd0, 1'b0},  // ignored
      '{1'b0, 32'h0001_0000, 1'b0, 7'd0, 1'b0},  // refill
      '{1'b0, 32'hAAAA_5555, 1'b1, 7'd0, 1'b0},
      '{1'b0, 32'h5555_AAAA, 1'b1, 7'd1, 1'b1},
      '{1'b0, 32'h0000_0000, 1'b1, 7'd0, 1'b0},
      '{1'b1, 32'h8000_0001, 1'b1, 7'd1, 1'b1}
   };

   localparam test_phase_type PHASES [NUM_PHASES] = '{
      '{8'd3,   8'd3,   8'd3,   CUT_ZERO,   4'd2},
      '{8'd4,   8'd5,   8'd3,   CUT_RANDOM, 4'd2},
      '{8'd5,   8'd4,   8'd6,   CUT_MIN,    4'd1},
      '{8'd255, 8'd1,   8'd1,   CUT_MAX,    4'd1},
      '{8'd6,   8'd3,   8'd5,   CUT_RANDOM, 4'd2},
      '{8'd1,   8'd128, 8'd0,   CUT_ZERO,   4'd1},
      '{8'd0,   8'd1,   8'd128, CUT_RANDOM, 4'd1},
      '{8'd3,   8'd8,   8'd4,   CUT_ZERO,   4'd3},
      '{8'd7,   8'd6,   8'd5,   CUT_RANDOM, 4'd1},
      '{8'd3,   8'd3,   8'd3,   CUT_RANDOM, 4'd2}
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   volume_surface_extract_3d dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the block: registers, delay line and counters
   logic [SIZE_W-1:0]        reg_size_x = SIZE_RESET;
   logic [SIZE_W-1:0]        reg_size_y = SIZE_RESET;
   logic [SIZE_W-1:0]        reg_size_z = SIZE_RESET;
   logic signed [DATA_W-1:0] reg_cutoff = CUTOFF_RESET;
   logic [DATA_W-1:0]        window_ring [LINE_DEPTH];
   int unsigned              ring_wr;
   int unsigned              fill_level;
   int unsigned              ox, oy, oz;
   bit                       volume_done;

   voxel_result_type awaited_voxels [$];
   int unsigned      fail_count;
   int unsigned      cycle_count;
   int unsigned      burst_left;
   bit               hold_request;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned clamp_extent(logic [SIZE_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   function automatic logic [DATA_W-1:0] ring_tap(int unsigned back);
      return window_ring[(ring_wr + LINE_DEPTH - 1 - (back % LINE_DEPTH)) % LINE_DEPTH];
   endfunction

   function automatic bit at_or_below(logic [DATA_W-1:0] v);
      return $signed(v) <= reg_cutoff;
   endfunction

   // advance the shadow by one item; returns 1 when the item releases a result
   function automatic bit surface_step(input bit flush, input logic [DATA_W-1:0] value,
                                       output voxel_result_type rsp);
      int unsigned       sx, sy, sz, plane;
      logic [DATA_W-1:0] centre;
      bit                surf, at_end;
      sx = clamp_extent(reg_size_x, DEF_MAX_X);
      sy = clamp_extent(reg_size_y, DEF_MAX_Y);
      sz = clamp_extent(reg_size_z, DEF_MAX_Z);
      plane = sx * sy;
      surf = 1'b0;
      centre = '0;
      rsp = '0;
      if (flush && volume_done) return 1'b0;
      if (!flush) volume_done = 1'b0;
      window_ring[ring_wr] = flush ? '0 : value;
      ring_wr = (ring_wr + 1) % LINE_DEPTH;
      if (fill_level < plane) begin
         fill_level++;
         return 1'b0;
      end
      // interior only: border voxels never look at their neighbors
      if (ox > 0 && ox + 1 < sx && oy > 0 && oy + 1 < sy && oz > 0 && oz + 1 < sz) begin
         centre = ring_tap(plane);
         if (!at_or_below(centre))
            surf = at_or_below(ring_tap(plane - 1)) || at_or_below(ring_tap(plane + 1)) ||
                   at_or_below(ring_tap(plane - sx)) || at_or_below(ring_tap(plane + sx)) ||
                   at_or_below(ring_tap(0)) || at_or_below(ring_tap(2 * plane));
      end
      at_end = (ox + 1 >= sx) && (oy + 1 >= sy) && (oz + 1 >= sz);
      rsp.value   = surf ? centre : '0;
      rsp.surface = surf;
      rsp.px      = ox[POS_W-1:0];
      rsp.py      = oy[POS_W-1:0];
      rsp.pz      = oz[POS_W-1:0];
      rsp.last    = at_end;
      if (at_end) begin
         ox = 0;
         oy = 0;
         oz = 0;
         volume_done = 1'b1;
         if (flush) fill_level = 0;
      end else if (ox + 1 < sx) begin
         ox++;
      end else begin
         ox = 0;
         if (oy + 1 < sy) begin
            oy++;
         end else begin
            oy = 0;
            oz++;
         end
      end
      return 1'b1;
   endfunction

   // densities clustered around the cutoff so that surfaces are common
   function automatic logic [DATA_W-1:0] pick_density();
      case ($urandom_range(0, 9))
         0, 1, 2: return reg_cutoff + $urandom_range(1, 3);
         3:       return reg_cutoff;
         4:       return reg_cutoff - $urandom_range(1, 2);
         5:       return $urandom();
         6:       return 32'h7FFF_FFFF;
         7:       return 32'h8000_0000;
         default: return reg_cutoff + $urandom_range(1, 16'hFFFF);
      endcase
   endfunction

   function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // append one expected result to the scoreboard
   task automatic queue_voxel(voxel_result_type rsp);
      awaited_voxels = {awaited_voxels, rsp};
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SIZE_X: reg_size_x = data[SIZE_W-1:0];
         CSR_SIZE_Y: reg_size_y = data[SIZE_W-1:0];
         CSR_SIZE_Z: reg_size_z = data[SIZE_W-1:0];
         CSR_CUTOFF: reg_cutoff = data;
         default: ;
      endcase
   endtask

   task automatic load_config(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                              logic [SIZE_W-1:0] sz, logic [DATA_W-1:0] cut);
      write_csr(CSR_SIZE_X, {{(CSR_DATA_W-SIZE_W){1'b0}}, sx});
      write_csr(CSR_SIZE_Y, {{(CSR_DATA_W-SIZE_W){1'b0}}, sy});
      write_csr(CSR_SIZE_Z, {{(CSR_DATA_W-SIZE_W){1'b0}}, sz});
      write_csr(CSR_CUTOFF, cut);
   endtask

   // offer one item at a falling edge, in bursts with random gaps
   task automatic offer_voxel(input bit flush, input logic [DATA_W-1:0] value,
                              output bit produced, output voxel_result_type rsp);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= flush ? REQ_KIND_FLUSH : KIND_DATA;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      produced = surface_step(flush, value, rsp);
      @(negedge clock);
   endtask

   task automatic send_and_expect(bit flush, logic [DATA_W-1:0] value);
      bit               produced;
      voxel_result_type rsp;
      offer_voxel(flush, value, produced, rsp);
      if (produced) queue_voxel(rsp);
   endtask

   task automatic stop_offering();
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   // all results in, then a few cycles for items that gave none
   task automatic wait_for_drain();
      while (awaited_voxels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // receiver: changing stall patterns plus one long hold-off on request
   initial begin
      ready_mode_type mode;
      int unsigned    seg, hold_left, tick;
      hold_left = 0;
      tick = 0;
      forever begin
         mode = ready_mode_type'($urandom_range(0, 3));
         seg = $urandom_range(20, 150);
         repeat (seg) begin
            @(negedge clock);
            tick++;
            if (hold_request) begin
               hold_request = 1'b0;
               hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_tready <= 1'b0;
            end else begin
               case (mode)
                  READY_ALWAYS: rsp_tready <= 1'b1;
                  READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
                  READY_MOSTLY: rsp_tready <= ($urandom_range(0, 4) != 0);
                  READY_SPARSE: rsp_tready <= (tick % 4 == 0);
                  default:      rsp_tready <= 1'b1;
               endcase
            end
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      voxel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_voxels.size() == 0) begin
            $error("unexpected result item: tdata %0h tuser %0b tlast %0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            fail_count++;
         end else begin
            want = awaited_voxels.pop_front();
            check_field("out_value", want.value, rsp_tdata[DATA_W-1:0]);
            check_field("pos_x", DATA_W'(want.px), DATA_W'(rsp_tdata[DATA_W +: POS_W]));
            check_field("pos_y", DATA_W'(want.py),
                        DATA_W'(rsp_tdata[DATA_W+POS_W +: POS_W]));
            check_field("pos_z", DATA_W'(want.pz),
                        DATA_W'(rsp_tdata[DATA_W+2*POS_W +: POS_W]));
            check_field("pad", '0, DATA_W'(rsp_tdata[RSP_TDATA_W-1 -: RSP_PAD_W]));
            check_field("is_surface", DATA_W'(want.surface), DATA_W'(rsp_tuser));
            check_field("last", DATA_W'(want.last), DATA_W'(rsp_tlast));
         end
      end
   end

   initial begin
      bit                produced;
      voxel_result_type  discard;
      logic [DATA_W-1:0] cut_val;
      int unsigned       sx, sy, sz, total, extra;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: border-only 1x1x2 volume with size 0 standing for 1
      load_config(8'd0, 8'd1, 8'd2, 32'h8000_0000);
      for (int r = 0; r < NUM_ROWS; r++) begin
         offer_voxel(DIRECTED_ROWS[r].flush, DIRECTED_ROWS[r].value, produced, discard);
         if (DIRECTED_ROWS[r].has_rsp)
            queue_voxel('{value: '0, surface: 1'b0, px: '0, py: '0,
                          pz: DIRECTED_ROWS[r].z, last: DIRECTED_ROWS[r].last});
      end
      stop_offering();
      wait_for_drain();

      // random volumes; each phase is drained by flushes before the next setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (PHASES[p].cut)
            CUT_ZERO: cut_val = '0;
            CUT_MIN:  cut_val = 32'h8000_0000;
            CUT_MAX:  cut_val = 32'h7FFF_FFFF;
            default:  cut_val = $urandom();
         endcase
         load_config(PHASES[p].size_x, PHASES[p].size_y, PHASES[p].size_z, cut_val);
         if (p == HOLD_PHASE) hold_request = 1'b1;
         sx = clamp_extent(reg_size_x, DEF_MAX_X);
         sy = clamp_extent(reg_size_y, DEF_MAX_Y);
         sz = clamp_extent(reg_size_z, DEF_MAX_Z);
         total = sx * sy * sz * PHASES[p].volumes;
         for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 49) == 0) send_and_expect(1'b1, $urandom());
            send_and_expect(1'b0, pick_density());
         end
         // sometimes leave part of a further volume in the pipeline
         if ($urandom_range(0, 2) == 0) begin
            extra = $urandom_range(1, sx * sy + 3);
            repeat (extra) send_and_expect(1'b0, pick_density());
         end
         // a flush is ignored once a volume is done, so a data voxel restarts it
         while (fill_level != 0) begin
            if (volume_done) send_and_expect(1'b0, pick_density());
            else send_and_expect(1'b1, $urandom());
         end
         repeat ($urandom_range(0, 2)) send_and_expect(1'b1, $urandom());
         stop_offering();
         wait_for_drain();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
